// ----- rtl/core/fwrv_pkg.sv -----
// ----------------------------------------------------------------------------
// fwrv_pkg
// Shared types and constants for the firmware image receive verifier.
// ----------------------------------------------------------------------------
package fwrv_pkg;

    localparam int unsigned MaxImageBytes = 2097152;
    localparam int unsigned MaxChunkBytes = 512;

    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

    typedef enum logic [2:0] {
        CMD_PREPARE = 3'd0,
        CMD_CHUNK_START = 3'd1,
        CMD_CHUNK_BYTE = 3'd2,
        CMD_VERIFY = 3'd3,
        CMD_COMMIT = 3'd4,
        CMD_ROLLBACK = 3'd5,
        CMD_CANCEL = 3'd6,
        CMD_STATUS = 3'd7
    } t_cmd;

    localparam logic [2:0] RC_OK = 3'd0;
    localparam logic [2:0] RC_BAD_STATE = 3'd1;
    localparam logic [2:0] RC_BAD_OFFSET = 3'd2;
    localparam logic [2:0] RC_BAD_SIZE = 3'd3;
    localparam logic [2:0] RC_NO_PART = 3'd4;
    localparam logic [2:0] RC_CRC = 3'd5;
    localparam logic [2:0] RC_EXT = 3'd6;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREPARED = 4'd1;
    localparam logic [3:0] ST_RECEIVING = 4'd2;
    localparam logic [3:0] ST_VERIFY_OK = 4'd4;
    localparam logic [3:0] ST_VERIFY_FAIL = 4'd5;
    localparam logic [3:0] ST_COMPLETE = 4'd7;
    localparam logic [3:0] ST_ERROR = 4'd8;
    localparam logic [3:0] ST_ROLLBACK = 4'd9;

    localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;
    localparam logic [1:0] REG_EXPECTED_CRC = 2'd1;
    localparam logic [1:0] REG_PARTITION_SIZE = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [23:0] chunk_offset;
        logic [15:0] chunk_len;
        logic [7:0]  data_byte;
        logic        ext_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  update_state;
        logic [7:0]  progress_pct;
        logic [23:0] received_bytes;
        logic [31:0] crc_value;
        logic        error_flag;
    } t_out_item;

    // Divider request and reply between the sequencer and the divide unit.
    typedef struct packed {
        logic        start;
        logic [30:0] dividend;
        logic [23:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot_sat;
    } t_div_rsp;

endpackage

// ----- rtl/core/fwrv_if.sv -----
// ----------------------------------------------------------------------------
// fwrv_in_if / fwrv_out_if
// Valid/ready channels that carry input and result items.
// ----------------------------------------------------------------------------
interface fwrv_in_if;
    logic               valid;
    logic               ready;
    fwrv_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fwrv_out_if;
    logic                valid;
    logic                ready;
    fwrv_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/firmware_image_receive_verifier.sv -----
// ----------------------------------------------------------------------------
// firmware_image_receive_verifier
// Firmware update sequencer with CRC-32 tracking and progress reporting.
// ----------------------------------------------------------------------------
// One item at a time: the block drops ready after accepting an item and
// raises it again once the result item has been taken. Most commands go
// through accept, execute and result steps. A chunk byte also waits on the
// bit-serial CRC unit (one bit a cycle). The last byte of a chunk, when the
// image size is nonzero, also waits on the one-bit-per-cycle progress
// divider. The result item is held until ready is seen. Configuration
// writes are taken at any time but are meant for when the block is idle.
module firmware_image_receive_verifier #(
    parameter int unsigned MAX_IMAGE_BYTES = fwrv_pkg::MaxImageBytes,
    parameter int unsigned MAX_CHUNK_BYTES = fwrv_pkg::MaxChunkBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    fwrv_in_if.sink     in_ch,
    fwrv_out_if.source  out_ch
);
    import fwrv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_CRC_WAIT, S_DIV_WAIT, S_OUT
    } t_seq;

    t_seq        r_seq;
    t_in_item    r_item;
    logic [23:0] r_image_size;
    logic [31:0] r_expected_crc;
    logic [23:0] r_partition_size;
    logic [3:0]  r_state;
    logic [23:0] r_count;
    logic [7:0]  r_progress;
    logic [31:0] r_crc;
    logic [31:0] r_chunk_crc;
    logic [15:0] r_pending;
    logic [15:0] r_open_len;
    logic        r_open;
    logic [2:0]  r_rc;
    logic        r_crc_start;
    t_div_req    r_div_req;
    t_div_rsp    div_rsp;
    logic        crc_done;
    logic [31:0] crc_out;
    logic        busy;
    logic [23:0] n_count;

    assign busy    = (r_state == ST_PREPARED) || (r_state == ST_RECEIVING);
    assign n_count = r_count + {8'd0, r_open_len};

    fwrv_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_crc_start),
        .i_crc   (r_chunk_crc),
        .i_byte  (r_item.data_byte),
        .o_done  (crc_done),
        .o_crc   (crc_out)
    );

    fwrv_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq            <= S_IDLE;
            r_image_size     <= '0;
            r_expected_crc   <= '0;
            r_partition_size <= '0;
            r_state          <= ST_IDLE;
            r_count          <= '0;
            r_progress       <= '0;
            r_crc            <= CrcInit;
            r_chunk_crc      <= CrcInit;
            r_pending        <= '0;
            r_open_len       <= '0;
            r_open           <= 1'b0;
            r_rc             <= RC_OK;
            r_crc_start      <= 1'b0;
            r_div_req        <= '0;
        end else begin
            r_crc_start     <= 1'b0;
            r_div_req.start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_SIZE:     r_image_size <= i_cfg_data[23:0];
                    REG_EXPECTED_CRC:   r_expected_crc <= i_cfg_data;
                    REG_PARTITION_SIZE: r_partition_size <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            case (r_seq)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_item <= in_ch.payload;
                        r_seq  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_rc  <= RC_OK;
                    r_seq <= S_OUT;
                    // every command but chunk byte and status closes a chunk
                    if (r_item.cmd != CMD_CHUNK_BYTE && r_item.cmd != CMD_STATUS) begin
                        r_open    <= 1'b0;
                        r_pending <= '0;
                    end
                    case (r_item.cmd)
                        CMD_PREPARE: begin
                            if (r_state != ST_IDLE) r_rc <= RC_BAD_STATE;
                            else if (r_image_size > 24'(MAX_IMAGE_BYTES)) r_rc <= RC_BAD_SIZE;
                            else if (r_partition_size == '0) r_rc <= RC_NO_PART;
                            else if (r_partition_size < r_image_size) r_rc <= RC_BAD_SIZE;
                            else if (!r_item.ext_ok) r_rc <= RC_EXT;
                            else begin
                                r_crc      <= CrcInit;
                                r_count    <= '0;
                                r_progress <= '0;
                                r_state    <= ST_PREPARED;
                            end
                        end
                        CMD_CHUNK_START: begin
                            if (!busy) r_rc <= RC_BAD_STATE;
                            else if (r_item.chunk_len == '0 ||
                                     r_item.chunk_len > 16'(MAX_CHUNK_BYTES)) begin
                                r_rc <= RC_BAD_SIZE;
                            end else if (r_item.chunk_offset != r_count) begin
                                r_rc <= RC_BAD_OFFSET;
                            end else begin
                                r_open      <= 1'b1;
                                r_pending   <= r_item.chunk_len;
                                r_open_len  <= r_item.chunk_len;
                                r_chunk_crc <= r_crc;
                            end
                        end
                        CMD_CHUNK_BYTE: begin
                            if (!r_open || !busy || r_pending == '0) begin
                                r_rc <= RC_BAD_STATE;
                            end else begin
                                r_crc_start <= 1'b1;
                                r_seq       <= S_CRC_WAIT;
                            end
                        end
                        CMD_VERIFY: begin
                            if (r_state != ST_RECEIVING) r_rc <= RC_BAD_STATE;
                            else if (r_count != r_image_size) begin
                                r_state <= ST_VERIFY_FAIL;
                                r_rc    <= RC_BAD_SIZE;
                            end else begin
                                r_crc <= r_crc ^ CrcInit;
                                if ((r_crc ^ CrcInit) != r_expected_crc) begin
                                    r_state <= ST_VERIFY_FAIL;
                                    r_rc    <= RC_CRC;
                                end else if (!r_item.ext_ok) begin
                                    r_state <= ST_VERIFY_FAIL;
                                    r_rc    <= RC_EXT;
                                end else begin
                                    r_state <= ST_VERIFY_OK;
                                end
                            end
                        end
                        CMD_COMMIT: begin
                            if (r_state != ST_VERIFY_OK) r_rc <= RC_BAD_STATE;
                            else if (!r_item.ext_ok) begin
                                r_state <= ST_ERROR;
                                r_rc    <= RC_EXT;
                            end else begin
                                r_state <= ST_COMPLETE;
                            end
                        end
                        CMD_ROLLBACK: begin
                            r_state <= ST_ROLLBACK;
                            if (!r_item.ext_ok) r_rc <= RC_EXT;
                        end
                        CMD_CANCEL: begin
                            r_count    <= '0;
                            r_progress <= '0;
                            r_state    <= ST_IDLE;
                        end
                        default: ;
                    endcase
                end
                S_CRC_WAIT: begin
                    if (crc_done) begin
                        r_chunk_crc <= crc_out;
                        r_pending   <= r_pending - 16'd1;
                        r_seq       <= S_OUT;
                        if (r_pending == 16'd1) begin
                            r_open <= 1'b0;
                            if (r_item.ext_ok) begin
                                r_crc   <= crc_out;
                                r_count <= n_count;
                                r_state <= ST_RECEIVING;
                                if (r_image_size != '0) begin
                                    r_div_req.start    <= 1'b1;
                                    r_div_req.dividend <= {7'd0, n_count} * 31'd100;
                                    r_div_req.divisor  <= r_image_size;
                                    r_seq              <= S_DIV_WAIT;
                                end
                            end else begin
                                r_state <= ST_ERROR;
                                r_rc    <= RC_EXT;
                            end
                        end
                    end
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_progress <= div_rsp.quot_sat;
                        r_seq      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) r_seq <= S_IDLE;
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready                   = (r_seq == S_IDLE);
    assign out_ch.valid                  = (r_seq == S_OUT);
    assign out_ch.payload.status         = r_rc;
    assign out_ch.payload.update_state   = r_state;
    assign out_ch.payload.progress_pct   = r_progress;
    assign out_ch.payload.received_bytes = r_count;
    assign out_ch.payload.crc_value      = r_crc;
    assign out_ch.payload.error_flag     = (r_state == ST_VERIFY_FAIL) || (r_state == ST_ERROR);
endmodule

// ----- rtl/core/fwrv_crc_unit.sv -----
// ----------------------------------------------------------------------------
// fwrv_crc_unit
// Bit-serial reflected CRC-32: one shift step per cycle, eight per byte.
// ----------------------------------------------------------------------------
module fwrv_crc_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic        o_done,
    output logic [31:0] o_crc
);
    import fwrv_pkg::*;

    logic [31:0] r_crc;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] n_step;

    always_comb begin
        n_step = r_crc[0] ? ((r_crc >> 1) ^ CrcPoly) : (r_crc >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_crc  <= i_crc ^ {24'd0, i_byte};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_crc <= n_step;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_crc;
endmodule

// ----- rtl/core/fwrv_div_unit.sv -----
// ----------------------------------------------------------------------------
// fwrv_div_unit
// Restoring divider, one quotient bit per cycle, result saturated at 255.
// ----------------------------------------------------------------------------
module fwrv_div_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fwrv_pkg::t_div_req  i_req,
    output fwrv_pkg::t_div_rsp  o_rsp
);
    import fwrv_pkg::*;

    localparam int NumBits = 31;

    logic [30:0] r_quot;
    logic [24:0] r_rem;
    logic [23:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] n_shift;
    logic [25:0] n_diff;

    always_comb begin
        n_shift = {r_rem[23:0], r_quot[30]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!n_diff[25]) begin
                    r_rem  <= n_diff[24:0];
                    r_quot <= {r_quot[29:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[29:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(NumBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quot_sat = (r_quot[30:8] != '0) ? 8'hFF : r_quot[7:0];
endmodule
